/* hdl/kwht_pkg.sv */
package kwht_pkg;

    // Default sizes of the table and the stored values.
    localparam int DEF_MAX_TABLE_LOG2   = 10;
    localparam int DEF_SLOTS_PER_BUCKET = 4;
    localparam int DEF_VALUE_BITS       = 16;

    // Terminator registers and the limit on how many of them are in use.
    localparam int TERM_REGS       = 4;
    localparam int MAX_TERMINATORS = 4;
    localparam int TERM_LIMIT      = (MAX_TERMINATORS < TERM_REGS) ? MAX_TERMINATORS
                                                                   : TERM_REGS;

    // Hash and field widths.
    localparam int HASH_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int EVAL_W  = 16;
    localparam int TVAL_W  = 16;
    localparam int TSL_W   = 4;
    localparam int TCNT_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 8;
    localparam int MODE_W  = 2;
    localparam int KIND_W  = 2;

    // Register reset values.
    localparam logic [TSL_W-1:0]  RST_TABLE_LOG2 = 4'd10;
    localparam logic [TCNT_W-1:0] RST_TERM_COUNT = 3'd1;
    localparam logic [BYTE_W-1:0] RST_TERM_A     = 8'd32;

    // Hash marker for a token whose running hash is zero, such as an empty token.
    localparam logic [HASH_W-1:0] HASH_TOP_BIT = {1'b1, {(HASH_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_TABLE_LOG2 = 3'd0;
    localparam logic [CIDX_W-1:0] REG_TERM_COUNT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TERM_A     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_TERM_B     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_TERM_C     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TERM_D     = 3'd5;

    // Input modes.
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_HIT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MISS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STORED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

/* hdl/keyword_hash_table_lookup.sv */
// Channel  Direction  Handshake                  Content
// s_*      in         s_tvalid / s_tready        mode in tuser, text byte and entry value
// m_*      out        m_tvalid / m_tready        kind in tuser, value, length and hash
// cfg_*    in         cfg_valid / cfg_ready      register index and write data
//
// A byte that does not end a token is folded in as it is taken, so such items go one per
// cycle while idle. An ending byte reads its bucket from the slot memory one slot per cycle
// via its registered read port; no item is taken until the result is in the output register.
// After reset and after a clear item the memory is swept, one entry per cycle, over all
// 2^MAX_TABLE_LOG2 * SLOTS_PER_BUCKET entries (4096 by default); no item is taken meanwhile.
// A held result in the output register stalls only the next ending byte, at its last step.
module keyword_hash_table_lookup #(
    parameter int MAX_TABLE_LOG2   = kwht_pkg::DEF_MAX_TABLE_LOG2,
    parameter int SLOTS_PER_BUCKET = kwht_pkg::DEF_SLOTS_PER_BUCKET,
    parameter int VALUE_BITS       = kwht_pkg::DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] text_byte, [23:8] entry_value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [15:0] token_value, [31:16] token_length,
                                   // [95:32] token_hash
    output logic [1:0]  m_tuser,   // [1:0] kind
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import kwht_pkg::*;

    localparam int DEPTH  = (1 << MAX_TABLE_LOG2) * SLOTS_PER_BUCKET;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int LG_W   = $clog2(MAX_TABLE_LOG2 + 1);
    localparam int ENT_W  = HASH_W + VALUE_BITS;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_BUCKET - 1);
    localparam logic [LG_W-1:0]   LG_MAX    = LG_W'(MAX_TABLE_LOG2);

    // Input fields.
    logic [MODE_W-1:0] in_mode;
    logic [BYTE_W-1:0] in_byte;
    logic [EVAL_W-1:0] in_value;

    assign in_mode  = s_tuser;
    assign in_byte  = s_tdata[7:0];
    assign in_value = s_tdata[23:8];

    // Registers.
    state_t             state_reg, state_next;
    logic [TSL_W-1:0]   tsl_reg;
    logic [TCNT_W-1:0]  tcnt_reg;
    logic [BYTE_W-1:0]  term_reg [TERM_REGS];

    logic [HASH_W-1:0]  run_hash_reg, run_hash_next;
    logic [2:0]         lane_reg, lane_next;
    logic [LEN_W-1:0]   count_reg, count_next;

    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               insert_reg, insert_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [VALUE_BITS-1:0] ev_reg, ev_next;
    logic [KIND_W-1:0]  res_kind_reg, res_kind_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [TVAL_W-1:0]  out_value_reg, out_value_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic [HASH_W-1:0]  out_hash_reg, out_hash_next;

    // Slot memory: hash in the upper bits, value in the lower bits.
    logic [ENT_W-1:0]   mem [DEPTH];
    logic [ENT_W-1:0]   rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENT_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [HASH_W-1:0]     rd_hash;
    logic [VALUE_BITS-1:0] rd_value;

    assign rd_hash  = rd_data_reg[ENT_W-1:VALUE_BITS];
    assign rd_value = rd_data_reg[VALUE_BITS-1:0];

    // Decode of the incoming item.
    logic                  accept;
    logic                  term_hit;
    logic                  ends_token;
    logic [BYTE_W-1:0]     low_byte;
    logic [TCNT_W-1:0]     term_n;
    logic [LG_W-1:0]       lg_eff;
    logic [MAX_TABLE_LOG2-1:0] bkt_mask;
    logic [ADDR_W-1:0]     bucket_base;
    logic [HASH_W-1:0]     final_hash;
    logic                  out_free;
    logic                  slot_found;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Terminator match against the registers in use.
    always_comb
    begin
        term_n = (tcnt_reg > TCNT_W'(TERM_LIMIT)) ? TCNT_W'(TERM_LIMIT) : tcnt_reg;
        term_hit = 1'b0;
        for (int i = 0; i < TERM_REGS; i++)
        begin
            if ((TCNT_W'(i) < term_n) && (term_reg[i] == in_byte))
            begin
                term_hit = 1'b1;
            end
        end
    end

    assign ends_token = ((in_mode == MODE_LOOKUP) && term_hit) ||
                        ((in_mode == MODE_INSERT) && (in_byte == '0));

    // Lowercase A-Z before folding.
    assign low_byte = ((in_byte >= 8'd65) && (in_byte <= 8'd90)) ? (in_byte + 8'd32) : in_byte;

    // Clamped bucket count and bucket base address.
    always_comb
    begin
        if (tsl_reg == '0)
        begin
            lg_eff = LG_W'(1);
        end
        else if (32'(tsl_reg) > 32'(MAX_TABLE_LOG2))
        begin
            lg_eff = LG_MAX;
        end
        else
        begin
            lg_eff = LG_W'(tsl_reg);
        end
        for (int i = 0; i < MAX_TABLE_LOG2; i++)
        begin
            bkt_mask[i] = (LG_W'(i) < lg_eff);
        end
    end

    // A zero running hash becomes the top bit alone, whose low bits are zero anyway.
    assign bucket_base = ADDR_W'(ADDR_W'(run_hash_reg[MAX_TABLE_LOG2-1:0] & bkt_mask) *
                                 ADDR_W'(SLOTS_PER_BUCKET));
    assign final_hash  = (run_hash_reg == '0) ? HASH_TOP_BIT : run_hash_reg;

    // A lookup stops on an equal hash, an insert on an empty slot.
    assign slot_found = insert_reg ? (rd_hash == '0) : (rd_hash == hash_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (in_mode == MODE_CLEAR))
                begin
                    state_next = ST_CLEAR;
                end
                else if (accept && ends_token)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (slot_found || (slot_reg == LAST_SLOT))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port controls.
    always_comb
    begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        mem_raddr = base_reg + ADDR_W'(slot_reg) + ADDR_W'(1);
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                mem_raddr = bucket_base;
            end
            ST_SCAN:
            begin
                mem_waddr = base_reg + ADDR_W'(slot_reg);
                mem_wdata = {hash_reg, ev_reg};
                mem_we    = insert_reg && slot_found;
            end
            ST_EMIT:
            begin
                mem_raddr = base_reg;
            end
            default:
            begin
                mem_raddr = base_reg;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        run_hash_next  = run_hash_reg;
        lane_next      = lane_reg;
        count_next     = count_reg;
        clr_addr_next  = clr_addr_reg;
        base_next      = base_reg;
        slot_next      = slot_reg;
        insert_next    = insert_reg;
        hash_next      = hash_reg;
        len_next       = len_reg;
        ev_next        = ev_reg;
        res_kind_next  = res_kind_reg;
        res_value_next = res_value_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_len_next   = out_len_reg;
        out_hash_next  = out_hash_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_CLEAR)
                    begin
                        run_hash_next = '0;
                        lane_next     = '0;
                        count_next    = '0;
                        clr_addr_next = '0;
                    end
                    else if (ends_token)
                    begin
                        // Capture the token and start the bucket scan at slot zero.
                        base_next     = bucket_base;
                        slot_next     = '0;
                        insert_next   = (in_mode == MODE_INSERT);
                        hash_next     = final_hash;
                        len_next      = count_reg;
                        ev_next       = VALUE_BITS'(in_value);
                        run_hash_next = '0;
                        lane_next     = '0;
                        count_next    = '0;
                    end
                    else if ((in_mode == MODE_LOOKUP) || (in_mode == MODE_INSERT))
                    begin
                        run_hash_next = run_hash_reg ^
                                        (HASH_W'(low_byte) << {lane_reg, 3'b000});
                        lane_next     = lane_reg + 3'd1;
                        if (count_reg != '1)
                        begin
                            count_next = count_reg + LEN_W'(1);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                slot_next = slot_reg + SLOT_W'(1);
                if (insert_reg)
                begin
                    res_kind_next  = slot_found ? KIND_STORED : KIND_FULL;
                    res_value_next = '0;
                end
                else
                begin
                    res_kind_next  = slot_found ? KIND_HIT : KIND_MISS;
                    res_value_next = slot_found ? rd_value : '0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_value_next = TVAL_W'(res_value_reg);
                    out_len_next   = len_reg;
                    out_hash_next  = hash_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            run_hash_reg  <= '0;
            lane_reg      <= '0;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            base_reg      <= '0;
            slot_reg      <= '0;
            insert_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_hash_reg  <= run_hash_next;
            lane_reg      <= lane_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            base_reg      <= base_next;
            slot_reg      <= slot_next;
            insert_reg    <= insert_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hash_reg      <= hash_next;
        len_reg       <= len_next;
        ev_reg        <= ev_next;
        res_kind_reg  <= res_kind_next;
        res_value_reg <= res_value_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_len_reg   <= out_len_next;
        out_hash_reg  <= out_hash_next;
    end

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsl_reg  <= RST_TABLE_LOG2;
            tcnt_reg <= RST_TERM_COUNT;
            term_reg[0] <= RST_TERM_A;
            for (int i = 1; i < TERM_REGS; i++)
            begin
                term_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TABLE_LOG2: tsl_reg     <= cfg_data[TSL_W-1:0];
                REG_TERM_COUNT: tcnt_reg    <= cfg_data[TCNT_W-1:0];
                REG_TERM_A:     term_reg[0] <= cfg_data;
                REG_TERM_B:     term_reg[1] <= cfg_data;
                REG_TERM_C:     term_reg[2] <= cfg_data;
                REG_TERM_D:     term_reg[3] <= cfg_data;
                default:
                begin
                    tsl_reg <= tsl_reg;
                end
            endcase
        end
    end

    // Slot memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Result channel.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_hash_reg, out_len_reg, out_value_reg};

endmodule

/* verif/keyword_hash_table_lookup_test.sv */
module keyword_hash_table_lookup_test;

    import kwht_pkg::*;

    localparam int SB_SLOTS = DEF_SLOTS_PER_BUCKET;
    localparam int SB_DEPTH = (1 << DEF_MAX_TABLE_LOG2) * SB_SLOTS;

    // One expected lookup or insert outcome.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TVAL_W-1:0] value;
        logic [LEN_W-1:0]  length;
        logic [HASH_W-1:0] hash;
    } token_result_t;

    // Keeps a private copy of the hash table and the token state, and queues the
    // outcome of every token or key that ends.
    class lookup_scoreboard;
        logic [HASH_W-1:0] running_hash;
        logic [2:0]        lane;
        logic [LEN_W-1:0]  length;
        logic [HASH_W-1:0] slot_hash[SB_DEPTH];
        logic [TVAL_W-1:0] slot_value[SB_DEPTH];
        logic [TSL_W-1:0]  table_log2;
        logic [TCNT_W-1:0] term_count;
        logic [BYTE_W-1:0] term_byte[TERM_REGS];
        token_result_t     outcome_q[$];
        int                errors;

        function new();
            table_log2 = RST_TABLE_LOG2;
            term_count = RST_TERM_COUNT;
            term_byte[0] = RST_TERM_A;
            term_byte[1] = '0;
            term_byte[2] = '0;
            term_byte[3] = '0;
            errors = 0;
            clear_table();
        endfunction

        // A clear empties every slot and also drops the token in progress.
        function void clear_table();
            foreach (slot_hash[i])
            begin
                slot_hash[i] = '0;
                slot_value[i] = '0;
            end
            running_hash = '0;
            lane = '0;
            length = '0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] index, logic [CDAT_W-1:0] data);
            case (index)
                REG_TABLE_LOG2: table_log2 = data[TSL_W-1:0];
                REG_TERM_COUNT: term_count = data[TCNT_W-1:0];
                REG_TERM_A:     term_byte[0] = data;
                REG_TERM_B:     term_byte[1] = data;
                REG_TERM_C:     term_byte[2] = data;
                REG_TERM_D:     term_byte[3] = data;
                default:        ;
            endcase
        endfunction

        function int active_terms();
            return (term_count > TERM_LIMIT) ? TERM_LIMIT : int'(term_count);
        endfunction

        function bit is_terminator(logic [BYTE_W-1:0] text);
            int i;
            for (i = 0; i < active_terms(); i++)
            begin
                if (term_byte[i] == text)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // Predicts the effect of one accepted input item.
        function void note_input(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] text,
                                 logic [EVAL_W-1:0] value);
            logic [HASH_W-1:0] h;
            logic [BYTE_W-1:0] folded;
            token_result_t     r;
            bit                ends;
            int                lg;
            int                base;
            int                i;
            if (mode == MODE_CLEAR)
            begin
                clear_table();
                return;
            end
            if (mode != MODE_LOOKUP && mode != MODE_INSERT)
                return;
            ends = (mode == MODE_LOOKUP) ? is_terminator(text) : (text == 8'd0);

            // A byte that does not end the token is lowercased and folded in.
            if (!ends)
            begin
                folded = (text >= 8'd65 && text <= 8'd90) ? text + 8'd32 : text;
                running_hash ^= {{(HASH_W-BYTE_W){1'b0}}, folded} << (8 * lane);
                lane++;
                if (length != '1)
                    length++;
                return;
            end

            // The token ends: finalize the hash and pick the bucket.
            h = (running_hash != '0) ? running_hash : HASH_TOP_BIT;
            lg = (table_log2 < 1) ? 1 :
                 (table_log2 > DEF_MAX_TABLE_LOG2) ? DEF_MAX_TABLE_LOG2 : int'(table_log2);
            base = int'(h & ((64'd1 << lg) - 64'd1)) * SB_SLOTS;
            r.value = '0;
            r.length = length;
            r.hash = h;
            if (mode == MODE_LOOKUP)
            begin
                r.kind = KIND_MISS;
                for (i = 0; i < SB_SLOTS; i++)
                begin
                    if (slot_hash[base + i] == h)
                    begin
                        r.kind = KIND_HIT;
                        r.value = slot_value[base + i];
                        break;
                    end
                end
            end
            else
            begin
                r.kind = KIND_FULL;
                for (i = 0; i < SB_SLOTS; i++)
                begin
                    if (slot_hash[base + i] == '0)
                    begin
                        slot_hash[base + i] = h;
                        slot_value[base + i] = value;
                        r.kind = KIND_STORED;
                        break;
                    end
                end
            end
            outcome_q.push_back(r);
            running_hash = '0;
            lane = '0;
            length = '0;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted result item against the oldest expectation.
        function void check_result(logic [KIND_W-1:0] kind, logic [95:0] data);
            token_result_t e;
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                         $time, kind, data);
                errors++;
                return;
            end
            e = outcome_q.pop_front();
            compare_field("kind", 64'(e.kind), 64'(kind));
            compare_field("token_value", 64'(e.value), 64'(data[15:0]));
            compare_field("token_length", 64'(e.length), 64'(data[31:16]));
            compare_field("token_hash", e.hash, data[95:32]);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_ITEMS    = 180;
    localparam int KEY_BANK       = 64;
    localparam int KEY_MAX        = 10;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [7:0] text_byte, [23:8] entry_value
    logic [1:0]  s_tuser;    // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;    // [15:0] token_value, [31:16] token_length, [95:32] token_hash
    logic [1:0]  m_tuser;    // [1:0] kind
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    lookup_scoreboard sb;
    bit  hold_req;
    bit  steady_input;
    bit  clear_since_drain;
    int  burst_left;
    int  traffic_count;
    logic [7:0] key_bytes[KEY_BANK][KEY_MAX];
    int  key_len[KEY_BANK];
    int  key_total;

    keyword_hash_table_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Offers one input item, in bursts with random gaps unless steady input is set, and waits for it to be taken.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [7:0] text, logic [15:0] value);
        int gap;
        if (!steady_input && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {value, text};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(mode, text, value);
        if (mode != MODE_UNUSED)
            traffic_count++;
        if (mode == MODE_CLEAR)
            clear_since_drain = 1'b1;
    endtask

    // Stops offering input, waits for every expected result, then lets the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (clear_since_drain ? 4200 : 16) @(posedge clk);
        clear_since_drain = 1'b0;
    endtask

    // Writes all six registers back to back.
    task automatic program_regs(logic [7:0] log2_val, logic [7:0] count_val, logic [7:0] t_a,
                                logic [7:0] t_b, logic [7:0] t_c, logic [7:0] t_d);
        logic [CIDX_W-1:0] idx[6];
        logic [7:0]        vals[6];
        int                i;
        idx  = '{REG_TABLE_LOG2, REG_TERM_COUNT, REG_TERM_A, REG_TERM_B, REG_TERM_C,
                 REG_TERM_D};
        vals = '{log2_val, count_val, t_a, t_b, t_c, t_d};
        for (i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_key_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(65, 90));
            1:       return 8'($urandom_range(97, 122));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Ends a lookup token with one of the active terminators, or with an insert
    // end when no terminator is in use.
    task automatic end_lookup_token();
        int n;
        n = sb.active_terms();
        if (n > 0)
            send_item(MODE_LOOKUP, sb.term_byte[$urandom_range(0, n - 1)],
                      16'($urandom_range(0, 65535)));
        else
            send_item(MODE_INSERT, 8'h00, 16'($urandom_range(0, 65535)));
    endtask

    // Mostly well-formed inserts and lookups of known keys, with noise, clears and broken tokens.
    task automatic random_traffic(int items);
        int start;
        int pick;
        int len;
        int k;
        int i;
        logic [7:0] b;
        start = traffic_count;
        while (traffic_count - start < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // Insert a new key into the bank.
                k = key_total % KEY_BANK;
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, KEY_MAX);
                key_len[k] = len;
                for (i = 0; i < len; i++)
                begin
                    b = random_key_byte();
                    key_bytes[k][i] = b;
                    send_item(MODE_INSERT, b, 16'($urandom_range(0, 65535)));
                end
                send_item(MODE_INSERT, 8'h00, 16'($urandom_range(0, 65535)));
                key_total++;
            end
            else if (pick < 80)
            begin
                // Look up a known key with its letters in random case, or a random token.
                if (key_total == 0 || $urandom_range(0, 7) == 0)
                begin
                    len = $urandom_range(0, KEY_MAX);
                    for (i = 0; i < len; i++)
                        send_item(MODE_LOOKUP, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
                end
                else
                begin
                    k = $urandom_range(0, ((key_total < KEY_BANK) ? key_total : KEY_BANK) - 1);
                    for (i = 0; i < key_len[k]; i++)
                    begin
                        b = key_bytes[k][i];
                        if (((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)) &&
                            $urandom_range(0, 1) == 1)
                            b = b ^ 8'h20;
                        send_item(MODE_LOOKUP, b, 16'($urandom_range(0, 65535)));
                    end
                end
                end_lookup_token();
            end
            else if (pick < 90)
            begin
                // Noise: random bytes in lookup, insert or the unused mode.
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                begin
                    k = $urandom_range(0, 3);
                    send_item((k == 2) ? MODE_UNUSED : 2'(k), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)));
                end
            end
            else if (pick < 92)
            begin
                send_item(MODE_CLEAR, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            end
            else
            begin
                // Broken token: insert bytes, an ignored item, then an end from end_lookup_token.
                len = $urandom_range(1, 5);
                for (i = 0; i < len; i++)
                    send_item(MODE_INSERT, random_key_byte(), 16'($urandom_range(0, 65535)));
                send_item(MODE_UNUSED, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
                end_lookup_token();
            end
        end
    endtask

    task automatic run_phase(logic [7:0] r0, logic [7:0] r1, logic [7:0] r2, logic [7:0] r3,
                             logic [7:0] r4, logic [7:0] r5, bit steady, bit long_hold,
                             bit mid_drain);
        drain();
        program_regs(r0, r1, r2, r3, r4, r5);
        steady_input = steady;
        if (long_hold)
            hold_req = 1'b1;
        if (mid_drain)
        begin
            random_traffic(PHASE_ITEMS / 2);
            drain();
            random_traffic(PHASE_ITEMS / 2);
        end
        else
        begin
            random_traffic(PHASE_ITEMS);
        end
        steady_input = 1'b0;
    endtask

    // Stimulus and the final verdict.
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        hold_req = 1'b0;
        steady_input = 1'b0;
        clear_since_drain = 1'b0;
        burst_left = 0;
        traffic_count = 0;
        key_total = 0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed tokens under the reset configuration.
        send_item(MODE_LOOKUP, 8'h20, 16'h0000);     // empty token misses
        send_item(MODE_INSERT, 8'h00, 16'hFFFF);     // empty key is stored
        send_item(MODE_LOOKUP, 8'h20, 16'h0000);     // and now hits
        send_item(MODE_INSERT, 8'h41, 16'h0000);
        send_item(MODE_INSERT, 8'h62, 16'h0000);
        send_item(MODE_INSERT, 8'h00, 16'h1234);
        send_item(MODE_LOOKUP, 8'h61, 16'h0000);     // same key in other case
        send_item(MODE_LOOKUP, 8'h42, 16'h0000);
        send_item(MODE_LOOKUP, 8'h20, 16'h0000);
        send_item(MODE_UNUSED, 8'h55, 16'hAAAA);     // ignored mode
        send_item(MODE_LOOKUP, 8'hFF, 16'h0000);     // high bytes, mixed modes
        send_item(MODE_INSERT, 8'h80, 16'h0000);
        send_item(MODE_LOOKUP, 8'h20, 16'h0000);
        send_item(MODE_LOOKUP, 8'h5A, 16'h0000);     // lookup byte, insert end
        send_item(MODE_INSERT, 8'h00, 16'h0000);
        repeat (4) send_item(MODE_INSERT, 8'h00, 16'h5A5A);   // duplicates until full
        send_item(MODE_LOOKUP, 8'h20, 16'h0000);     // first duplicate wins
        send_item(MODE_CLEAR, 8'h00, 16'h0000);
        send_item(MODE_LOOKUP, 8'h20, 16'h0000);     // table is empty again

        // A long token, sent without gaps, that wraps the byte lane many times.
        steady_input = 1'b1;
        repeat (120) send_item(MODE_LOOKUP, 8'h51, 16'($urandom_range(0, 65535)));
        send_item(MODE_LOOKUP, 8'h20, 16'h0000);
        steady_input = 1'b0;

        // Random phases over a range of settings.
        run_phase(8'h0A, 8'h01, 8'h20, 8'h2C, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
        run_phase(8'h01, 8'h04, 8'h20, 8'h0A, 8'h3B, 8'hFF, 1'b0, 1'b1, 1'b0);
        run_phase(8'h00, 8'h02, 8'h2E, 8'h2C, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        run_phase(8'h0F, 8'h07, 8'h20, 8'h09, 8'h0D, 8'h0A, 1'b0, 1'b0, 1'b1);
        run_phase(8'h02, 8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
        run_phase(8'hF3, 8'hFB, 8'h00, 8'h20, 8'hFF, 8'($urandom_range(0, 255)),
                  1'b0, 1'b0, 1'b0);
        run_phase(8'h5A, 8'h04, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'h20, 1'b0, 1'b0, 1'b0);
        run_phase(8'h01, 8'h01, 8'h00, 8'h41, 8'h42, 8'h43, 1'b0, 1'b0, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: checks accepted items and drives its own stall pattern.
    initial
    begin : result_sink
        int cyc;
        int hold_left;
        cyc = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            cyc++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case ((cyc / 200) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_tready <= ((cyc % 5) < 3);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Ends the run when no handshake of any kind happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

endmodule

/* keyword_hash_table_lookup.f */
hdl/kwht_pkg.sv
hdl/keyword_hash_table_lookup.sv
verif/keyword_hash_table_lookup_test.sv
